>>> rtl/core/mts_pkg.sv
package mts_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CODE_W = 34;
  localparam int unsigned FILL_W = 11;

  localparam logic signed [VAL_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] EMPTY_TOP = -32'sd1;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] min_value;
    logic                    is_empty;
    logic [FILL_W-1:0]       fill_count;
    logic [1:0]              status;
  } out_t;

  // Stored codes below the minimum are encoded; the minimum itself is the value.
  function automatic logic signed [VAL_W-1:0] decode_top(
    input logic signed [CODE_W-1:0] code,
    input logic signed [VAL_W-1:0]  minv
  );
    logic signed [CODE_W-1:0] min_ext;
    min_ext = $signed({{(CODE_W-VAL_W){minv[VAL_W-1]}}, minv});
    return (code >= min_ext) ? $signed(code[VAL_W-1:0]) : minv;
  endfunction

endpackage

>>> rtl/core/min_tracking_stack_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_stall_o | in_data_i  (mts_pkg::in_t)
// out     | output    | out_valid_o, out_stall_i | out_data_o (mts_pkg::out_t)
//
// Push, read and pops that leave the stack empty take a new item at once unless
// the output stalls. A pop with entries left below the top waits in S_POP_WAIT
// while the entry store is read to refill the cached top register.
// Reset loads the minimum with the largest signed value and empties the stack;
// the entry store needs no clearing since only entries below the count are read.
// The input stalls while a pop refill is pending or a stalled result holds
// the output register.
module min_tracking_stack_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mts_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mts_pkg::out_t  out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mts_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic signed [mts_pkg::VAL_W-1:0]  min_q, min_d;
  logic signed [mts_pkg::CODE_W-1:0] top_q, top_d;
  logic            out_valid_q;
  mts_pkg::out_t   out_q, res;
  logic            out_load;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [mts_pkg::CODE_W-1:0]  mem_rdata;

  logic out_free, in_acc, full, empty;
  logic signed [mts_pkg::CODE_W-1:0] push_ext, push_enc, min_ext;
  logic [mts_pkg::VAL_W-1:0]         min_restore;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != mts_pkg::S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(DEPTH));
  assign empty      = (cnt_q == '0);

  assign push_ext = $signed({{2{in_data_i.push_value[mts_pkg::VAL_W-1]}},
                             in_data_i.push_value});
  assign min_ext  = $signed({{2{min_q[mts_pkg::VAL_W-1]}}, min_q});
  assign push_enc = $signed({in_data_i.push_value[mts_pkg::VAL_W-1],
                             in_data_i.push_value, 1'b0}) - min_ext;
  assign min_restore = {min_q[mts_pkg::VAL_W-2:0], 1'b0} - top_q[mts_pkg::VAL_W-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    min_d     = min_q;
    top_d     = top_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(cnt_q - CW'(1));
    mem_raddr = AW'(cnt_q - CW'(2));
    res.top_value  = empty ? mts_pkg::EMPTY_TOP : mts_pkg::decode_top(top_q, min_q);
    res.min_value  = min_q;
    res.is_empty   = empty;
    res.fill_count = mts_pkg::FILL_W'(cnt_q);
    res.status     = mts_pkg::ST_OK;
    case (state_q)
      mts_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.req_type)
            mts_pkg::REQ_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                res.status = mts_pkg::ST_FULL;
              end else begin
                // Spill the cached top into the store.
                mem_we = !empty;
                cnt_d  = cnt_q + CW'(1);
                top_d  = push_ext;
                if (empty) begin
                  min_d = in_data_i.push_value;
                end else if (in_data_i.push_value < min_q) begin
                  top_d = push_enc;
                  min_d = in_data_i.push_value;
                end
                res.top_value  = in_data_i.push_value;
                res.min_value  = min_d;
                res.is_empty   = 1'b0;
                res.fill_count = mts_pkg::FILL_W'(cnt_d);
              end
            end
            mts_pkg::REQ_POP: begin
              if (empty) begin
                out_load   = 1'b1;
                res.status = mts_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (top_q < min_ext) begin
                  min_d = $signed(min_restore);
                end
                if (cnt_q == CW'(1)) begin
                  out_load       = 1'b1;
                  res.top_value  = mts_pkg::EMPTY_TOP;
                  res.min_value  = min_d;
                  res.is_empty   = 1'b1;
                  res.fill_count = '0;
                end else begin
                  // Fetch the entry below; result follows the refill.
                  mem_re  = 1'b1;
                  state_d = mts_pkg::S_POP_WAIT;
                end
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      mts_pkg::S_POP_WAIT: begin
        if (out_free) begin
          top_d          = $signed(mem_rdata);
          out_load       = 1'b1;
          res.top_value  = mts_pkg::decode_top($signed(mem_rdata), min_q);
          res.is_empty   = 1'b0;
          state_d        = mts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::S_IDLE;
      cnt_q       <= '0;
      min_q       <= mts_pkg::MIN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  mts_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_write_in_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mts_pkg::S_POP_WAIT |-> !mem_we)
    else $error("store written during pop refill");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result overwrites a stalled item");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.req_type == mts_pkg::REQ_PUSH && !full
    |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("push did not advance count");

endmodule

>>> rtl/core/mts_mem.sv
module mts_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [mts_pkg::CODE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [mts_pkg::CODE_W-1:0] rdata_o
);

  logic [mts_pkg::CODE_W-1:0] mem [DEPTH];
  logic [mts_pkg::CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/min_tracking_stack_unit_tb.sv
module min_tracking_stack_unit_tb;
  import mts_pkg::*;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam int unsigned MAX_REPORTS = 10;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  // Predicted stack contents, encoded the same way the block stores them
  logic signed [CODE_W-1:0] code_mem [STACK_DEPTH];
  logic signed [VAL_W-1:0]  min_reg = MIN_RESET;
  int unsigned              depth_cnt = 0;
  out_t                     stack_results_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len = 0;
  logic        hold_active = 1'b0;
  int unsigned mismatch_count = 0;

  min_tracking_stack_unit #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic step_min_stack(input in_t item, output out_t res);
    longint      v;
    longint      x;
    longint      code;
    logic [63:0] restored;
    res = '0;
    res.status = ST_OK;
    v = item.push_value;
    case (item.req_type)
      REQ_PUSH: begin
        if (depth_cnt >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          code = v;
          if (depth_cnt == 0) begin
            min_reg = v[VAL_W-1:0];
          end else if (v < min_reg) begin
            // store 2*v - min so the old minimum can be recovered on pop
            code = 2 * v - min_reg;
            min_reg = v[VAL_W-1:0];
          end
          code_mem[depth_cnt] = code[CODE_W-1:0];
          depth_cnt++;
        end
      end
      REQ_POP: begin
        if (depth_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          depth_cnt--;
          x = code_mem[depth_cnt];
          if (x < min_reg) begin
            restored = 2 * longint'(min_reg) - x;
            min_reg = restored[VAL_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (depth_cnt == 0) begin
      res.top_value = EMPTY_TOP;
    end else begin
      x = code_mem[depth_cnt-1];
      res.top_value = (x >= min_reg) ? x[VAL_W-1:0] : min_reg;
    end
    res.min_value  = min_reg;
    res.is_empty   = (depth_cnt == 0);
    res.fill_count = FILL_W'(depth_cnt);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_push_value();
    int unsigned sel;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = $signed($urandom());
    end else if (sel < 60) begin
      // land on or around the current minimum to hit the equal case
      v = longint'(min_reg) + longint'($urandom_range(8)) - 4;
      if (v > INT_MAX) v = INT_MAX;
      if (v < INT_MIN) v = INT_MIN;
    end else if (sel < 75) begin
      case ($urandom_range(3))
        0: v = INT_MIN;
        1: v = INT_MAX;
        2: v = 0;
        default: v = -1;
      endcase
    end else begin
      v = longint'($urandom_range(200)) - 100;
    end
    return v[VAL_W-1:0];
  endfunction

  task automatic send_item(input logic [1:0] req, input logic signed [VAL_W-1:0] value);
    in_t  item;
    out_t res;
    item.req_type   = req;
    item.push_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    step_min_stack(item, res);
    stack_results_q.push_back(res);
  endtask

  task automatic send_random_items(input int unsigned count);
    int unsigned sel;
    logic [1:0]  req;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (depth_cnt > 48) begin
        req = (sel < 55) ? REQ_POP : (sel < 85) ? REQ_PUSH : REQ_READ;
      end else begin
        req = (sel < 45) ? REQ_PUSH : (sel < 78) ? REQ_POP :
              (sel < 93) ? REQ_READ : REQ_UNUSED;
      end
      send_item(req, (req == REQ_PUSH) ? pick_push_value() : $signed($urandom()));
    end
  endtask

  task automatic test_empty_stack();
    send_item(REQ_READ, 0);
    send_item(REQ_POP, -1);
    send_item(REQ_UNUSED, INT_MIN);
    send_item(REQ_PUSH, 5);
    send_item(REQ_PUSH, -3);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
    // minimum holds its last value once the stack drains
    send_item(REQ_READ, 0);
    send_item(REQ_PUSH, 100);
    send_item(REQ_POP, 0);
  endtask

  task automatic test_extreme_values();
    send_item(REQ_PUSH, INT_MAX);
    send_item(REQ_PUSH, INT_MIN);
    send_item(REQ_PUSH, INT_MIN);
    send_item(REQ_PUSH, INT_MAX);
    send_item(REQ_READ, INT_MAX);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
    send_item(REQ_PUSH, 32'sh5555_5555);
    send_item(REQ_PUSH, 32'shAAAA_AAAA);
    send_item(REQ_PUSH, -1);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
    send_item(REQ_POP, 0);
  endtask

  task automatic test_output_backpressure();
    hold_len = 300;
    send_random_items(40);
  endtask

  // long receiver hold-off, counted here so the sender keeps offering items
  always begin
    @(posedge clk_i);
    if (hold_len > 0) begin
      hold_active <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
      hold_active <= 1'b0;
      hold_len = 0;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stack_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: top=%0d min=%0d empty=%0b fill=%0d status=%0d",
                   out_data_o.top_value, out_data_o.min_value, out_data_o.is_empty,
                   out_data_o.fill_count, out_data_o.status);
      end else begin
        want = stack_results_q.pop_front();
        if (out_data_o.top_value !== want.top_value ||
            out_data_o.min_value !== want.min_value ||
            out_data_o.is_empty !== want.is_empty ||
            out_data_o.fill_count !== want.fill_count ||
            out_data_o.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected top=%0d min=%0d empty=%0b fill=%0d status=%0d",
                     want.top_value, want.min_value, want.is_empty, want.fill_count,
                     want.status);
            $display("          got      top=%0d min=%0d empty=%0b fill=%0d status=%0d",
                     out_data_o.top_value, out_data_o.min_value,
                     out_data_o.is_empty, out_data_o.fill_count, out_data_o.status);
          end
        end
      end
    end
    out_stall_i <= hold_active || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("min_tracking_stack_unit_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 74;
    test_empty_stack();
    test_extreme_values();
    send_random_items(130);

    send_idle_pct = 74;
    recv_idle_pct = 25;
    send_random_items(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_items(100);
    test_output_backpressure();

    in_valid_i <= 1'b0;
    while (stack_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && stack_results_q.size() == 0) begin
      $display("min_tracking_stack_unit_tb OK");
    end else begin
      $display("min_tracking_stack_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
